/* src/cir_pkg.sv */
// Shared widths, constants, register codes and helpers for the contact impulse resolver.
`default_nettype none

package cir_pkg;

    localparam int FRAC_BITS = 16;

    localparam int NORM_W   = 18;
    localparam int PEN_W    = 31;
    localparam int VEL_W    = 32;
    localparam int MASS_W   = 40;
    localparam int BOUNCE_W = 17;
    localparam int TS_W     = 31;
    localparam int BF_W     = 17;
    localparam int SLOP_W   = 17;
    localparam int MAXB_W   = 31;

    localparam int INV_Q_W    = 32 + FRAC_BITS + 1;
    localparam int SUM_W      = INV_Q_W + 1;
    localparam int RSUM_W     = 31;
    localparam int NORM_STEPS = SUM_W - RSUM_W;
    localparam int NORM_LAT   = NORM_STEPS + 1;
    localparam int RATIO_W    = 33;
    localparam int NUM_W      = 40;
    localparam int FRONT_LAT  = 5;
    localparam int APPLY_LAT  = 4;
    localparam int PASS_LAT   = INV_Q_W + NORM_LAT + RATIO_W;
    localparam int TOTAL_LAT  = 1 + PASS_LAT + APPLY_LAT;

    localparam logic [INV_Q_W-1:0] INV_DIVIDEND = INV_Q_W'(1) << (32 + FRAC_BITS);
    localparam logic [MASS_W-1:0]  ABSENT_MASS  = MASS_W'(64'd100000 << FRAC_BITS);
    localparam logic [17:0]        ONE_FX       = 18'(1) << FRAC_BITS;

    localparam logic [1:0] REG_INV_TIMESTEP = 2'd0;
    localparam logic [1:0] REG_BIAS_FACTOR  = 2'd1;
    localparam logic [1:0] REG_PEN_SLOP     = 2'd2;
    localparam logic [1:0] REG_MAX_BIAS     = 2'd3;

    localparam logic [TS_W-1:0]   RST_INV_TIMESTEP = TS_W'(3932160);
    localparam logic [BF_W-1:0]   RST_BIAS_FACTOR  = BF_W'(16384);
    localparam logic [SLOP_W-1:0] RST_PEN_SLOP     = SLOP_W'(328);
    localparam logic [MAXB_W-1:0] RST_MAX_BIAS     = MAXB_W'(196608);

    typedef struct packed {
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [VEL_W-1:0]  v1x;
        logic signed [VEL_W-1:0]  v1y;
        logic signed [VEL_W-1:0]  v2x;
        logic signed [VEL_W-1:0]  v2y;
        logic [1:0]               present;
    } side_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/cir_delay.sv */
// Enabled shift line that delays a word by a fixed number of stages.
`default_nettype none

module cir_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [W-1:0] d,
    output logic      [W-1:0] q
);

    logic [W-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk) begin
        if (en) begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

/* src/cir_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module cir_div_pipe #(
    parameter int DEN_W = 8,
    parameter int Q_W   = 8
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [DEN_W-1:0] rem_in,
    input  wire logic [Q_W-1:0]   bits_in,
    input  wire logic [DEN_W-1:0] den_in,
    output logic      [Q_W-1:0]   quo
);

    logic [DEN_W-1:0] rem_reg  [Q_W];
    logic [DEN_W-1:0] den_reg  [Q_W];
    logic [Q_W-1:0]   bits_reg [Q_W];
    logic [Q_W-1:0]   quo_reg  [Q_W];

    genvar i;
    for (i = 0; i < Q_W; i++) begin : g_stage
        logic [DEN_W-1:0] rem_i;
        logic [DEN_W-1:0] den_i;
        logic [Q_W-1:0]   bits_i;
        logic [Q_W-1:0]   quo_i;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] rem_next;

        if (i == 0) begin : g_first
            assign rem_i  = rem_in;
            assign den_i  = den_in;
            assign bits_i = bits_in;
            assign quo_i  = '0;
        end else begin : g_next
            assign rem_i  = rem_reg[i-1];
            assign den_i  = den_reg[i-1];
            assign bits_i = bits_reg[i-1];
            assign quo_i  = quo_reg[i-1];
        end

        assign trial    = {rem_i, bits_i[Q_W-1]};
        assign ge       = trial >= {1'b0, den_i};
        assign rem_next = ge ? DEN_W'(trial - {1'b0, den_i}) : DEN_W'(trial);

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[i]  <= rem_next;
                den_reg[i]  <= den_i;
                bits_reg[i] <= bits_i << 1;
                quo_reg[i]  <= {quo_i[Q_W-2:0], ge};
            end
        end
    end

    assign quo = quo_reg[Q_W-1];

endmodule

`default_nettype wire

/* src/cir_norm.sv */
// Inverse mass sum and joint right shift until the sum fits 31 bits.
`default_nettype none

module cir_norm (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [cir_pkg::INV_Q_W-1:0]   inv1_in,
    input  wire logic [cir_pkg::INV_Q_W-1:0]   inv2_in,
    output logic      [cir_pkg::RSUM_W-1:0]    inv1,
    output logic      [cir_pkg::RSUM_W-1:0]    inv2,
    output logic      [cir_pkg::RSUM_W-1:0]    sum,
    output logic                               skipped
);

    import cir_pkg::*;

    logic [SUM_W-1:0] a_reg   [NORM_LAT];
    logic [SUM_W-1:0] b_reg   [NORM_LAT];
    logic [SUM_W-1:0] s_reg   [NORM_LAT];
    logic             skp_reg [NORM_LAT];
    logic [SUM_W-1:0] sum_next;

    assign sum_next = SUM_W'(inv1_in) + SUM_W'(inv2_in);

    always_ff @(posedge clk) begin
        if (en) begin
            a_reg[0]   <= SUM_W'(inv1_in);
            b_reg[0]   <= SUM_W'(inv2_in);
            s_reg[0]   <= sum_next;
            skp_reg[0] <= (sum_next == '0);
        end
    end

    genvar k;
    for (k = 1; k < NORM_LAT; k++) begin : g_shift
        logic big;
        assign big = |s_reg[k-1][SUM_W-1:RSUM_W];

        always_ff @(posedge clk) begin
            if (en) begin
                a_reg[k]   <= big ? (a_reg[k-1] >> 1) : a_reg[k-1];
                b_reg[k]   <= big ? (b_reg[k-1] >> 1) : b_reg[k-1];
                s_reg[k]   <= big ? (s_reg[k-1] >> 1) : s_reg[k-1];
                skp_reg[k] <= skp_reg[k-1];
            end
        end
    end

    assign inv1    = a_reg[NORM_LAT-1][RSUM_W-1:0];
    assign inv2    = b_reg[NORM_LAT-1][RSUM_W-1:0];
    assign sum     = s_reg[NORM_LAT-1][RSUM_W-1:0];
    assign skipped = skp_reg[NORM_LAT-1];

endmodule

`default_nettype wire

/* src/cir_front.sv */
// Closing speed, restitution impulse, bias and position shift pipeline.
`default_nettype none

module cir_front (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic signed [cir_pkg::NORM_W-1:0]   nx,
    input  wire logic signed [cir_pkg::NORM_W-1:0]   ny,
    input  wire logic        [cir_pkg::PEN_W-1:0]    pen,
    input  wire logic signed [cir_pkg::VEL_W-1:0]    v1x,
    input  wire logic signed [cir_pkg::VEL_W-1:0]    v1y,
    input  wire logic signed [cir_pkg::VEL_W-1:0]    v2x,
    input  wire logic signed [cir_pkg::VEL_W-1:0]    v2y,
    input  wire logic        [1:0]                   present,
    input  wire logic        [cir_pkg::BOUNCE_W-1:0] bounce,
    input  wire logic                                first_pass,
    input  wire logic        [cir_pkg::TS_W-1:0]     inverse_timestep,
    input  wire logic        [cir_pkg::BF_W-1:0]     bias_factor,
    input  wire logic        [cir_pkg::SLOP_W-1:0]   penetration_slop,
    input  wire logic        [cir_pkg::MAXB_W-1:0]   max_bias_speed,
    output logic             [cir_pkg::NUM_W-1:0]    num,
    output logic signed      [31:0]                  shift_x,
    output logic signed      [31:0]                  shift_y
);

    import cir_pkg::*;

    // stage 1
    logic signed [VEL_W-1:0] e1x, e1y, e2x, e2y;
    logic signed [VEL_W:0]   rvx_reg, rvy_reg;
    logic [47:0]             t_reg;
    logic                    over1_reg;
    logic [PEN_W-1:0]        diff_reg;
    logic signed [48:0]      shx1_reg, shy1_reg;
    logic signed [NORM_W-1:0] nx1_reg, ny1_reg;
    logic [BOUNCE_W-1:0]     e1_reg;
    logic                    first1_reg;

    assign e1x = present[0] ? v1x : '0;
    assign e1y = present[0] ? v1y : '0;
    assign e2x = present[1] ? v2x : '0;
    assign e2y = present[1] ? v2y : '0;

    always_ff @(posedge clk) begin
        if (en) begin
            rvx_reg    <= (VEL_W+1)'(e2x) - (VEL_W+1)'(e1x);
            rvy_reg    <= (VEL_W+1)'(e2y) - (VEL_W+1)'(e1y);
            t_reg      <= 48'(bias_factor) * 48'(inverse_timestep);
            over1_reg  <= first_pass && (pen > PEN_W'(penetration_slop));
            diff_reg   <= pen - PEN_W'(penetration_slop);
            shx1_reg   <= 49'(nx) * $signed({18'd0, pen});
            shy1_reg   <= 49'(ny) * $signed({18'd0, pen});
            nx1_reg    <= nx;
            ny1_reg    <= ny;
            e1_reg     <= bounce;
            first1_reg <= first_pass;
        end
    end

    // stage 2
    logic signed [50:0] dpx_reg, dpy_reg;
    logic [62:0]        bp_reg;
    logic               over2_reg;
    logic [BOUNCE_W-1:0] e2_reg;
    logic signed [31:0] shx2_reg, shy2_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            dpx_reg   <= 51'(rvx_reg) * 51'(nx1_reg);
            dpy_reg   <= 51'(rvy_reg) * 51'(ny1_reg);
            bp_reg    <= 63'(t_reg[47:FRAC_BITS]) * 63'(diff_reg);
            over2_reg <= over1_reg;
            e2_reg    <= e1_reg;
            shx2_reg  <= first1_reg ? sat32(64'(shx1_reg >>> (FRAC_BITS + 1))) : '0;
            shy2_reg  <= first1_reg ? sat32(64'(shy1_reg >>> (FRAC_BITS + 1))) : '0;
        end
    end

    // stage 3
    logic signed [51:0] dsum;
    logic [46:0]        bq;
    logic signed [35:0] van_reg;
    logic [MAXB_W-1:0]  bias3_reg;
    logic [BOUNCE_W-1:0] e3_reg;
    logic signed [31:0] shx3_reg, shy3_reg;

    assign dsum = 52'(dpx_reg) + 52'(dpy_reg);
    assign bq   = bp_reg[62:FRAC_BITS];

    always_ff @(posedge clk) begin
        if (en) begin
            van_reg   <= 36'(dsum >>> FRAC_BITS);
            bias3_reg <= !over2_reg ? '0 :
                         (bq > 47'(max_bias_speed)) ? max_bias_speed : MAXB_W'(bq);
            e3_reg    <= e2_reg;
            shx3_reg  <= shx2_reg;
            shy3_reg  <= shy2_reg;
        end
    end

    // stage 4
    logic [35:0]        vmag;
    logic [17:0]        rest;
    logic [53:0]        jnp_reg;
    logic [MAXB_W-1:0]  bias4_reg;
    logic signed [31:0] shx4_reg, shy4_reg;

    assign vmag = van_reg[35] ? 36'(-van_reg) : '0;
    assign rest = ONE_FX + 18'(e3_reg);

    always_ff @(posedge clk) begin
        if (en) begin
            jnp_reg   <= 54'(rest) * 54'(vmag);
            bias4_reg <= bias3_reg;
            shx4_reg  <= shx3_reg;
            shy4_reg  <= shy3_reg;
        end
    end

    // stage 5
    logic [NUM_W-1:0]   num_reg;
    logic signed [31:0] shx5_reg, shy5_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            num_reg  <= NUM_W'(jnp_reg[53:FRAC_BITS]) + NUM_W'(bias4_reg);
            shx5_reg <= shx4_reg;
            shy5_reg <= shy4_reg;
        end
    end

    assign num     = num_reg;
    assign shift_x = shx5_reg;
    assign shift_y = shy5_reg;

endmodule

`default_nettype wire

/* src/cir_apply.sv */
// Impulse split by mass ratio, scaled along the normal and applied to each body.
`default_nettype none

module cir_apply (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [cir_pkg::NUM_W-1:0]       num,
    input  wire logic [cir_pkg::RATIO_W-1:0]     r1,
    input  wire logic [cir_pkg::RATIO_W-1:0]     r2,
    input  wire logic                            skipped_in,
    input  wire cir_pkg::side_t                  side,
    output logic signed [31:0]                   new_first_vel_x,
    output logic signed [31:0]                   new_first_vel_y,
    output logic signed [31:0]                   new_second_vel_x,
    output logic signed [31:0]                   new_second_vel_y,
    output logic                                 skipped
);

    import cir_pkg::*;

    side_t side1_reg, side2_reg, side3_reg;
    logic  skp1_reg, skp2_reg, skp3_reg;

    // stage 1: partial products of num * r
    logic [64:0] plo1_reg, plo2_reg;
    logic [40:0] phi1_reg, phi2_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            plo1_reg  <= 65'(num[31:0]) * 65'(r1);
            plo2_reg  <= 65'(num[31:0]) * 65'(r2);
            phi1_reg  <= 41'(num[NUM_W-1:32]) * 41'(r1);
            phi2_reg  <= 41'(num[NUM_W-1:32]) * 41'(r2);
            side1_reg <= side;
            skp1_reg  <= skipped_in;
        end
    end

    // stage 2: s = floor(num * r / 2^32)
    logic [40:0] s1_reg, s2_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            s1_reg    <= phi1_reg + 41'(plo1_reg[64:32]);
            s2_reg    <= phi2_reg + 41'(plo2_reg[64:32]);
            side2_reg <= side1_reg;
            skp2_reg  <= skp1_reg;
        end
    end

    // stage 3: delta magnitudes
    logic [NORM_W-1:0] magx, magy;
    logic [58:0]       p1x, p1y, p2x, p2y;
    logic [42:0]       d1x_reg, d1y_reg, d2x_reg, d2y_reg;

    assign magx = side2_reg.nx[NORM_W-1] ? NORM_W'(-side2_reg.nx) : NORM_W'(side2_reg.nx);
    assign magy = side2_reg.ny[NORM_W-1] ? NORM_W'(-side2_reg.ny) : NORM_W'(side2_reg.ny);
    assign p1x  = 59'(s1_reg) * 59'(magx);
    assign p1y  = 59'(s1_reg) * 59'(magy);
    assign p2x  = 59'(s2_reg) * 59'(magx);
    assign p2y  = 59'(s2_reg) * 59'(magy);

    always_ff @(posedge clk) begin
        if (en) begin
            d1x_reg   <= p1x[58:FRAC_BITS];
            d1y_reg   <= p1y[58:FRAC_BITS];
            d2x_reg   <= p2x[58:FRAC_BITS];
            d2y_reg   <= p2y[58:FRAC_BITS];
            side3_reg <= side2_reg;
            skp3_reg  <= skp2_reg;
        end
    end

    // stage 4: apply and saturate
    logic signed [44:0] dl1x, dl1y, dl2x, dl2y;
    logic signed [44:0] o1x, o1y, o2x, o2y;
    logic               app1, app2;
    logic signed [31:0] o1x_reg, o1y_reg, o2x_reg, o2y_reg;
    logic               skp4_reg;

    assign dl1x = side3_reg.nx[NORM_W-1] ? -$signed({2'b0, d1x_reg}) : $signed({2'b0, d1x_reg});
    assign dl1y = side3_reg.ny[NORM_W-1] ? -$signed({2'b0, d1y_reg}) : $signed({2'b0, d1y_reg});
    assign dl2x = side3_reg.nx[NORM_W-1] ? -$signed({2'b0, d2x_reg}) : $signed({2'b0, d2x_reg});
    assign dl2y = side3_reg.ny[NORM_W-1] ? -$signed({2'b0, d2y_reg}) : $signed({2'b0, d2y_reg});
    assign o1x  = 45'(side3_reg.v1x) - dl1x;
    assign o1y  = 45'(side3_reg.v1y) - dl1y;
    assign o2x  = 45'(side3_reg.v2x) + dl2x;
    assign o2y  = 45'(side3_reg.v2y) + dl2y;
    assign app1 = side3_reg.present[0] && !skp3_reg;
    assign app2 = side3_reg.present[1] && !skp3_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            o1x_reg  <= app1 ? sat32(64'(o1x)) : side3_reg.v1x;
            o1y_reg  <= app1 ? sat32(64'(o1y)) : side3_reg.v1y;
            o2x_reg  <= app2 ? sat32(64'(o2x)) : side3_reg.v2x;
            o2y_reg  <= app2 ? sat32(64'(o2y)) : side3_reg.v2y;
            skp4_reg <= skp3_reg;
        end
    end

    assign new_first_vel_x  = o1x_reg;
    assign new_first_vel_y  = o1y_reg;
    assign new_second_vel_x = o2x_reg;
    assign new_second_vel_y = o2y_reg;
    assign skipped          = skp4_reg;

endmodule

`default_nettype wire

/* src/contact_impulse_resolver.sv */
// Top level of the contact impulse resolver: register port, item pipeline and dividers.
//
// Usage:
//   Input channel (in_valid/in_ready), unless stalled, takes one contact item per cycle:
//   normal, penetration, both velocities and masses, presence bits, bounce, first_pass.
//   Output channel (out_valid/out_ready) returns one result item per contact,
//   in order: updated velocities, position shift and the skipped flag.
//   Registers sit on the APB port at byte addresses 0, 4, 8, 12; write them only
//   while no item is in flight. pready is tied high.
//   From acceptance to out_valid an item passes one input register, 49 divider
//   stages for the inverse masses, 20 stages for the mass sum and normalizing
//   shift, 33 divider stages for the mass ratios and 4 apply stages.
//   Throughput is one item per cycle unless stalled, every stage taking a new item.
//   Reset clears the item valid bits and loads the register defaults; the
//   datapath itself is not cleared.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated. Bubbles still advance
//   while the output slot is empty.
`default_nettype none

module contact_impulse_resolver (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic        [3:0]                   paddr,
    input  wire logic        [31:0]                  pwdata,
    output logic             [31:0]                  prdata,
    output logic                                     pready,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [cir_pkg::NORM_W-1:0]   normal_x,
    input  wire logic signed [cir_pkg::NORM_W-1:0]   normal_y,
    input  wire logic        [cir_pkg::PEN_W-1:0]    penetration,
    input  wire logic signed [cir_pkg::VEL_W-1:0]    first_vel_x,
    input  wire logic signed [cir_pkg::VEL_W-1:0]    first_vel_y,
    input  wire logic signed [cir_pkg::VEL_W-1:0]    second_vel_x,
    input  wire logic signed [cir_pkg::VEL_W-1:0]    second_vel_y,
    input  wire logic        [cir_pkg::MASS_W-1:0]   first_mass,
    input  wire logic        [cir_pkg::MASS_W-1:0]   second_mass,
    input  wire logic        [1:0]                   body_present,
    input  wire logic        [cir_pkg::BOUNCE_W-1:0] bounce,
    input  wire logic                                first_pass,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed      [31:0]                  new_first_vel_x,
    output logic signed      [31:0]                  new_first_vel_y,
    output logic signed      [31:0]                  new_second_vel_x,
    output logic signed      [31:0]                  new_second_vel_y,
    output logic signed      [31:0]                  shift_x,
    output logic signed      [31:0]                  shift_y,
    output logic                                     skipped
);

    import cir_pkg::*;

    // register port
    logic [TS_W-1:0]   inv_ts_reg;
    logic [BF_W-1:0]   bias_f_reg;
    logic [SLOP_W-1:0] slop_reg;
    logic [MAXB_W-1:0] maxb_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            inv_ts_reg <= RST_INV_TIMESTEP;
            bias_f_reg <= RST_BIAS_FACTOR;
            slop_reg   <= RST_PEN_SLOP;
            maxb_reg   <= RST_MAX_BIAS;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_INV_TIMESTEP: inv_ts_reg <= pwdata[TS_W-1:0];
                REG_BIAS_FACTOR:  bias_f_reg <= pwdata[BF_W-1:0];
                REG_PEN_SLOP:     slop_reg   <= pwdata[SLOP_W-1:0];
                REG_MAX_BIAS:     maxb_reg   <= pwdata[MAXB_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_INV_TIMESTEP: prdata = 32'(inv_ts_reg);
            REG_BIAS_FACTOR:  prdata = 32'(bias_f_reg);
            REG_PEN_SLOP:     prdata = 32'(slop_reg);
            REG_MAX_BIAS:     prdata = 32'(maxb_reg);
        endcase
    end

    // pipeline control
    logic                 adv;
    logic [TOTAL_LAT-1:0] vld_reg;
    logic [TOTAL_LAT-1:0] vld_next;

    assign adv       = !vld_reg[TOTAL_LAT-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[TOTAL_LAT-1];
    assign vld_next  = {vld_reg[TOTAL_LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // input stage
    side_t               side_reg;
    logic [PEN_W-1:0]    pen_reg;
    logic [MASS_W-1:0]   m1_reg, m2_reg;
    logic [BOUNCE_W-1:0] e_reg;
    logic                first_reg;

    always_ff @(posedge clk) begin
        if (adv) begin
            side_reg.nx      <= normal_x;
            side_reg.ny      <= normal_y;
            side_reg.v1x     <= first_vel_x;
            side_reg.v1y     <= first_vel_y;
            side_reg.v2x     <= second_vel_x;
            side_reg.v2y     <= second_vel_y;
            side_reg.present <= body_present;
            pen_reg          <= penetration;
            m1_reg           <= first_mass;
            m2_reg           <= second_mass;
            e_reg            <= bounce;
            first_reg        <= first_pass;
        end
    end

    // a zero mass divides like a mass of one: the quotient equals the dividend INV_DIVIDEND
    logic [MASS_W-1:0] m1_div, m2_div;

    assign m1_div = !side_reg.present[0] ? ABSENT_MASS :
                    (m1_reg == '0) ? MASS_W'(1) : m1_reg;
    assign m2_div = !side_reg.present[1] ? ABSENT_MASS :
                    (m2_reg == '0) ? MASS_W'(1) : m2_reg;

    logic [INV_Q_W-1:0] inv1, inv2;

    cir_div_pipe #(.DEN_W(MASS_W), .Q_W(INV_Q_W)) u_inv1 (
        .clk(clk), .en(adv), .rem_in('0), .bits_in(INV_DIVIDEND), .den_in(m1_div), .quo(inv1)
    );

    cir_div_pipe #(.DEN_W(MASS_W), .Q_W(INV_Q_W)) u_inv2 (
        .clk(clk), .en(adv), .rem_in('0), .bits_in(INV_DIVIDEND), .den_in(m2_div), .quo(inv2)
    );

    logic [RSUM_W-1:0] inv1_n, inv2_n, sum_n;
    logic              skp_n;

    cir_norm u_norm (
        .clk(clk), .en(adv), .inv1_in(inv1), .inv2_in(inv2),
        .inv1(inv1_n), .inv2(inv2_n), .sum(sum_n), .skipped(skp_n)
    );

    logic [RATIO_W-1:0] r1, r2;

    cir_div_pipe #(.DEN_W(RSUM_W), .Q_W(RATIO_W)) u_ratio1 (
        .clk(clk), .en(adv),
        .rem_in({1'b0, inv1_n[RSUM_W-1:1]}),
        .bits_in({inv1_n[0], 32'd0}),
        .den_in(sum_n), .quo(r1)
    );

    cir_div_pipe #(.DEN_W(RSUM_W), .Q_W(RATIO_W)) u_ratio2 (
        .clk(clk), .en(adv),
        .rem_in({1'b0, inv2_n[RSUM_W-1:1]}),
        .bits_in({inv2_n[0], 32'd0}),
        .den_in(sum_n), .quo(r2)
    );

    logic [NUM_W-1:0]   num_f;
    logic signed [31:0] shx_f, shy_f;

    cir_front u_front (
        .clk(clk), .en(adv),
        .nx(side_reg.nx), .ny(side_reg.ny), .pen(pen_reg),
        .v1x(side_reg.v1x), .v1y(side_reg.v1y), .v2x(side_reg.v2x), .v2y(side_reg.v2y),
        .present(side_reg.present), .bounce(e_reg), .first_pass(first_reg),
        .inverse_timestep(inv_ts_reg), .bias_factor(bias_f_reg),
        .penetration_slop(slop_reg), .max_bias_speed(maxb_reg),
        .num(num_f), .shift_x(shx_f), .shift_y(shy_f)
    );

    logic [$bits(side_t)-1:0] side_dly;
    side_t                    side_a;
    logic [NUM_W-1:0]         num_a;
    logic                     skp_a;
    logic [63:0]              shift_dly;

    cir_delay #(.W($bits(side_t)), .DEPTH(PASS_LAT)) u_side_dly (
        .clk(clk), .en(adv), .d(side_reg), .q(side_dly)
    );

    assign side_a = side_t'(side_dly);

    cir_delay #(.W(NUM_W), .DEPTH(PASS_LAT - FRONT_LAT)) u_num_dly (
        .clk(clk), .en(adv), .d(num_f), .q(num_a)
    );

    cir_delay #(.W(1), .DEPTH(RATIO_W)) u_skp_dly (
        .clk(clk), .en(adv), .d(skp_n), .q(skp_a)
    );

    cir_delay #(.W(64), .DEPTH(PASS_LAT + APPLY_LAT - FRONT_LAT)) u_shift_dly (
        .clk(clk), .en(adv), .d({shx_f, shy_f}), .q(shift_dly)
    );

    assign shift_x = shift_dly[63:32];
    assign shift_y = shift_dly[31:0];

    cir_apply u_apply (
        .clk(clk), .en(adv), .num(num_a), .r1(r1), .r2(r2),
        .skipped_in(skp_a), .side(side_a),
        .new_first_vel_x(new_first_vel_x), .new_first_vel_y(new_first_vel_y),
        .new_second_vel_x(new_second_vel_x), .new_second_vel_y(new_second_vel_y),
        .skipped(skipped)
    );

    a_no_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !skipped)
        else $error("inverse mass sum reached zero");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_reg[0])
        else $error("accepted item missing from first stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_stall_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("item taken while result stalled");

endmodule

`default_nettype wire

/* tb/sv/contact_impulse_resolver_tb.sv */
// Testbench for the contact impulse resolver: directed table, random contacts, predictor check.
`timescale 1ns / 1ps

module contact_impulse_resolver_tb;
    import cir_pkg::*;

    typedef struct {
        logic signed [NORM_W-1:0]   nx;
        logic signed [NORM_W-1:0]   ny;
        logic        [PEN_W-1:0]    pen;
        logic signed [VEL_W-1:0]    v1x;
        logic signed [VEL_W-1:0]    v1y;
        logic signed [VEL_W-1:0]    v2x;
        logic signed [VEL_W-1:0]    v2y;
        logic        [MASS_W-1:0]   m1;
        logic        [MASS_W-1:0]   m2;
        logic        [1:0]          present;
        logic        [BOUNCE_W-1:0] e;
        logic                       first;
    } contact_t;

    typedef struct {
        logic signed [31:0] v1x;
        logic signed [31:0] v1y;
        logic signed [31:0] v2x;
        logic signed [31:0] v2y;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic               skip;
    } outcome_t;

    typedef struct {
        contact_t c;
        bit       fixed;
        outcome_t o;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    contact_t drv = '{default: '0};
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] r_v1x, r_v1y, r_v2x, r_v2y, r_sx, r_sy;
    logic r_skip;

    logic [TS_W-1:0]   cfg_its  = RST_INV_TIMESTEP;
    logic [BF_W-1:0]   cfg_bf   = RST_BIAS_FACTOR;
    logic [SLOP_W-1:0] cfg_slop = RST_PEN_SLOP;
    logic [MAXB_W-1:0] cfg_maxb = RST_MAX_BIAS;

    outcome_t pending_results[$];
    int errors = 0;
    int accepted = 0;
    int checked = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;

    contact_impulse_resolver dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .normal_x(drv.nx), .normal_y(drv.ny), .penetration(drv.pen),
        .first_vel_x(drv.v1x), .first_vel_y(drv.v1y),
        .second_vel_x(drv.v2x), .second_vel_y(drv.v2y),
        .first_mass(drv.m1), .second_mass(drv.m2),
        .body_present(drv.present), .bounce(drv.e), .first_pass(drv.first),
        .out_valid(out_valid), .out_ready(out_ready),
        .new_first_vel_x(r_v1x), .new_first_vel_y(r_v1y),
        .new_second_vel_x(r_v2x), .new_second_vel_y(r_v2y),
        .shift_x(r_sx), .shift_y(r_sy), .skipped(r_skip)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #3000000;
        $display("contact_impulse_resolver_tb NOT OK");
        $finish;
    end

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] along_normal(input logic signed [63:0] n,
                                                        input logic [63:0] s);
        logic [63:0] mag;
        logic [63:0] d;
        mag = (n < 0) ? 64'(-n) : 64'(n);
        if (mag != 0 && s > (64'h4000000000000000 / mag))
            d = 64'h1 << 40;
        else
            d = (s * mag) >> FRAC_BITS;
        return (n < 0) ? -$signed(d) : $signed(d);
    endfunction

    function automatic logic [63:0] inverse_of(input logic [63:0] m);
        if (m == 0)
            return 64'h1 << (32 + FRAC_BITS);
        return (64'h1 << (32 + FRAC_BITS)) / m;
    endfunction

    function automatic outcome_t resolve_contact(input contact_t c);
        outcome_t o;
        logic signed [63:0] nx, ny, in1x, in1y, in2x, in2y, v1x, v1y, v2x, v2y, van;
        logic [63:0] m1, m2, inv1, inv2, total, jn, bias, t, diff, num, r1, r2, s1, s2;
        logic [127:0] prod;
        bit p1, p2;
        nx = 64'(c.nx);
        ny = 64'(c.ny);
        in1x = 64'(c.v1x); in1y = 64'(c.v1y); in2x = 64'(c.v2x); in2y = 64'(c.v2y);
        p1 = c.present[0];
        p2 = c.present[1];
        m1 = p1 ? 64'(c.m1) : 64'(ABSENT_MASS);
        m2 = p2 ? 64'(c.m2) : 64'(ABSENT_MASS);
        v1x = p1 ? in1x : 64'sd0; v1y = p1 ? in1y : 64'sd0;
        v2x = p2 ? in2x : 64'sd0; v2y = p2 ? in2y : 64'sd0;
        o.v1x = clamp32(in1x); o.v1y = clamp32(in1y);
        o.v2x = clamp32(in2x); o.v2y = clamp32(in2y);
        o.sx = '0;
        o.sy = '0;
        o.skip = 1'b0;
        if (c.first) begin
            o.sx = clamp32((nx * $signed({33'b0, c.pen})) >>> (FRAC_BITS + 1));
            o.sy = clamp32((ny * $signed({33'b0, c.pen})) >>> (FRAC_BITS + 1));
        end
        inv1 = inverse_of(m1);
        inv2 = inverse_of(m2);
        total = inv1 + inv2;
        if (total == 0) begin
            o.skip = 1'b1;
        end else begin
            van = ((v2x - v1x) * nx + (v2y - v1y) * ny) >>> FRAC_BITS;
            jn = '0;
            bias = '0;
            if (van < 0)
                jn = ((64'h10000 + 64'(c.e)) * 64'(-van)) >> FRAC_BITS;
            if (c.first && 64'(c.pen) > 64'(cfg_slop)) begin
                t = (64'(cfg_bf) * 64'(cfg_its)) >> FRAC_BITS;
                diff = 64'(c.pen) - 64'(cfg_slop);
                if (t != 0 && diff > (64'h8000000000000000 / t) - 1)
                    bias = 64'(cfg_maxb);
                else
                    bias = (t * diff) >> FRAC_BITS;
                if (bias > 64'(cfg_maxb))
                    bias = 64'(cfg_maxb);
            end
            num = jn + bias;
            while (total >= (64'h1 << 31)) begin
                total = total >> 1;
                inv1 = inv1 >> 1;
                inv2 = inv2 >> 1;
            end
            r1 = (inv1 << 32) / total;
            r2 = (inv2 << 32) / total;
            if (p1) begin
                prod = 128'(num) * 128'(r1);
                s1 = prod[95:32];
                o.v1x = clamp32(in1x - along_normal(nx, s1));
                o.v1y = clamp32(in1y - along_normal(ny, s1));
            end
            if (p2) begin
                prod = 128'(num) * 128'(r2);
                s2 = prod[95:32];
                o.v2x = clamp32(in2x + along_normal(nx, s2));
                o.v2y = clamp32(in2y + along_normal(ny, s2));
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("MISMATCH result %0d %s: got %h expected %h", checked, field, got, want);
    endtask

    always @(posedge clk)
    begin
        outcome_t w;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("MISMATCH result %0d arrived with none expected", checked);
            end else begin
                w = pending_results.pop_front();
                if (r_v1x !== w.v1x) report_mismatch("new_first_vel_x", r_v1x, w.v1x);
                if (r_v1y !== w.v1y) report_mismatch("new_first_vel_y", r_v1y, w.v1y);
                if (r_v2x !== w.v2x) report_mismatch("new_second_vel_x", r_v2x, w.v2x);
                if (r_v2y !== w.v2y) report_mismatch("new_second_vel_y", r_v2y, w.v2y);
                if (r_sx !== w.sx) report_mismatch("shift_x", r_sx, w.sx);
                if (r_sy !== w.sy) report_mismatch("shift_y", r_sy, w.sy);
                if (r_skip !== w.skip)
                    report_mismatch("skipped", 32'(r_skip), 32'(w.skip));
            end
            checked++;
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_INV_TIMESTEP: cfg_its  = value[TS_W-1:0];
            REG_BIAS_FACTOR:  cfg_bf   = value[BF_W-1:0];
            REG_PEN_SLOP:     cfg_slop = value[SLOP_W-1:0];
            default:          cfg_maxb = value[MAXB_W-1:0];
        endcase
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TOTAL_LAT + 10) @(posedge clk);
    endtask

    // called at a falling edge; returns at a falling edge after acceptance
    task automatic offer(input contact_t c, input bit fixed, input outcome_t o);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        drv = c;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.insert(pending_results.size(), fixed ? o : resolve_contact(c));
        accepted++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic logic signed [31:0] rand_vel();
        case ($urandom_range(0, 3))
            0: return $signed($urandom);
            1: return $signed($urandom_range(0, 32'h400000)) - 32'sh200000;
            default: return $signed($urandom_range(0, 32'h4000000)) - 32'sh2000000;
        endcase
    endfunction

    function automatic logic [MASS_W-1:0] rand_mass();
        case ($urandom_range(0, 7))
            0: return MASS_W'({$urandom, $urandom});
            1: return MASS_W'($urandom_range(0, 3));
            2: return '1;
            default: return MASS_W'($urandom_range(1, 32'h2000000));
        endcase
    endfunction

    function automatic contact_t rand_contact();
        contact_t c;
        case ($urandom_range(0, 4))
            0: begin c.nx = NORM_W'($urandom); c.ny = NORM_W'($urandom); end
            1: begin
                c.nx = $urandom_range(0, 1) ? NORM_W'(65536) : NORM_W'(-65536);
                c.ny = '0;
            end
            2: begin
                c.ny = $urandom_range(0, 1) ? NORM_W'(65536) : NORM_W'(-65536);
                c.nx = '0;
            end
            default: begin
                c.nx = NORM_W'($signed($urandom_range(0, 131072)) - 65536);
                c.ny = NORM_W'($signed($urandom_range(0, 131072)) - 65536);
            end
        endcase
        c.pen = $urandom_range(0, 1) ? PEN_W'($urandom_range(0, 4000)) : PEN_W'($urandom);
        c.v1x = rand_vel(); c.v1y = rand_vel();
        c.v2x = rand_vel(); c.v2y = rand_vel();
        c.m1 = rand_mass();
        c.m2 = rand_mass();
        c.present = 2'($urandom);
        c.e = ($urandom_range(0, 3) == 0) ? BOUNCE_W'($urandom)
                                          : BOUNCE_W'($urandom_range(0, 65536));
        c.first = 1'($urandom);
        return c;
    endfunction

    row_t directed[$];
    outcome_t none;

    task automatic add_row(input contact_t c);
        directed.insert(directed.size(), '{c: c, fixed: 1'b0, o: '{default: '0}});
    endtask

    initial
    begin
        contact_t c;
        outcome_t o;
        logic [31:0] cfg_val[4];
        none = '{default: '0};

        // idle contact: absent bodies, no first pass
        c = '{default: '0};
        c.v1x = 32'sh7fffffff; c.v1y = 32'sh80000000; c.v2x = 123; c.v2y = -5;
        o = '{v1x: 32'sh7fffffff, v1y: 32'sh80000000, v2x: 123, v2y: -5,
              sx: 0, sy: 0, skip: 1'b0};
        directed.insert(directed.size(), '{c: c, fixed: 1'b1, o: o});
        // shift only: absent bodies, first pass
        c = '{default: '0};
        c.nx = NORM_W'(65536); c.pen = PEN_W'(2); c.first = 1'b1;
        o = '{default: '0};
        o.sx = 1;
        directed.insert(directed.size(), '{c: c, fixed: 1'b1, o: o});

        c = '{default: '0};
        c.nx = NORM_W'(65536); c.v1x = 32'sh10000; c.v2x = -32'sh10000;
        c.m1 = 40'h10000; c.m2 = 40'h10000; c.present = 2'b11; c.e = BOUNCE_W'(65536);
        add_row(c);
        c.first = 1'b1; c.pen = 31'h7fffffff; add_row(c);
        c.nx = NORM_W'(-65536); c.ny = '0; c.present = 2'b01; add_row(c);
        c.present = 2'b10; add_row(c);
        c.nx = '0; c.ny = NORM_W'(65536); c.v1y = 32'sh7fffffff; c.v2y = 32'sh80000000;
        c.present = 2'b11; add_row(c);
        c.m1 = '0; c.m2 = '0; add_row(c);
        c.m1 = '1; c.m2 = '1; add_row(c);
        c.m1 = MASS_W'(1); c.m2 = '1; c.e = '1; add_row(c);
        c.nx = 18'sh1ffff; c.ny = 18'sh20000; c.m1 = '0; c.m2 = MASS_W'(1); add_row(c);
        c.v1x = 32'sh80000000; c.v2x = 32'sh7fffffff;
        c.nx = NORM_W'(-65536); c.ny = NORM_W'(-65536);
        add_row(c);
        c.first = 1'b1; c.pen = PEN_W'(329); c.v1x = '0; c.v2x = '0; c.v1y = '0; c.v2y = '0;
        add_row(c);
        c.pen = PEN_W'(328); add_row(c);
        c.pen = '0; c.present = 2'b00; add_row(c);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < directed.size(); i++)
            offer(directed[i].c, directed[i].fixed, directed[i].o);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: cfg_val = '{$urandom, $urandom_range(0, 65536),
                               $urandom_range(0, 65536), $urandom};
                1: cfg_val = '{32'hffffffff, 32'h10000, 32'h0, 32'h7fffffff};
                2: cfg_val = '{32'h0, 32'h0, 32'h1ffff, 32'h0};
                default: cfg_val = '{32'h3c0000, 32'h4000, 32'h148, 32'h30000};
            endcase
            for (int r = 0; r < 4; r++)
                reg_write(r[1:0], cfg_val[r]);
            @(negedge clk);
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 72 : 0;
            recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 21 : 0;
            if (phase == 2)
                hold_cycles = 400;
            for (int k = 0; k < 310; k++)
                offer(rand_contact(), 1'b0, none);
            drain();
        end

        $display("Covered %0d contacts (%0d results checked) over five register settings,",
                 accepted, checked);
        $display("with sender and receiver idling and one long receiver stall.");
        if (errors == 0)
            $display("contact_impulse_resolver_tb OK");
        else
            $display("contact_impulse_resolver_tb NOT OK");
        $finish;
    end

endmodule
